// File: sv/mmss_pkg.sv
// ----------------------------------------------------------------------------
// mmss_pkg - shared types and constants of the seven-segment scan clock
// Set-mode codes, configuration register indexes, reset values and the
// display control bundle handed to the segment encoder.
// ----------------------------------------------------------------------------
package mmss_pkg;

    // set mode of the clock
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_SET_MIN = 2'd1,
        MODE_SET_SEC = 2'd2
    } mode_t;

    // configuration register indexes
    localparam logic [1:0] REG_TICKS_PER_SECOND  = 2'd0;
    localparam logic [1:0] REG_BLINK_HALF_PERIOD = 2'd1;
    localparam logic [1:0] REG_COMMON_CATHODE    = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration reset values
    localparam logic [15:0] TICKS_PER_SECOND_RST  = 16'd1000;
    localparam logic [15:0] BLINK_HALF_PERIOD_RST = 16'd250;

    // time reset values and wrap limits
    localparam logic [4:0] HOUR_RST   = 5'd12;
    localparam logic [5:0] MINUTE_RST = 6'd12;
    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;

    // display control bundle for the segment encoder
    typedef struct packed {
        mode_t      mode;
        logic       blink_visible;
        logic       common_cathode;
        logic [1:0] scan_pos;
    } disp_ctrl_t;

endpackage

// File: sv/mmss_seg_enc.sv
// ----------------------------------------------------------------------------
// mmss_seg_enc - segment and digit-enable encoder for one scan position
// Picks the MM:SS digit for the scan position, looks up its glyph, adds the
// decimal point, applies polarity and blanking, and remaps to the pin byte.
// ----------------------------------------------------------------------------
module mmss_seg_enc (
    input  logic [5:0]          minute_count,
    input  logic [5:0]          second_count,
    input  mmss_pkg::disp_ctrl_t ctrl,
    output logic [7:0]          segment_pins,
    output logic [3:0]          digit_select
);

    // split a value below 64 into tens and units
    function automatic logic [7:0] split_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] base;
        begin
            if (v >= 6'd60) begin
                tens = 4'd6; base = 6'd60;
            end else if (v >= 6'd50) begin
                tens = 4'd5; base = 6'd50;
            end else if (v >= 6'd40) begin
                tens = 4'd4; base = 6'd40;
            end else if (v >= 6'd30) begin
                tens = 4'd3; base = 6'd30;
            end else if (v >= 6'd20) begin
                tens = 4'd2; base = 6'd20;
            end else if (v >= 6'd10) begin
                tens = 4'd1; base = 6'd10;
            end else begin
                tens = 4'd0; base = 6'd0;
            end
            split_bcd = {tens, 4'(v - base)};
        end
    endfunction

    // common-cathode glyphs, gfedcba; anything above nine shows nine
    function automatic logic [7:0] glyph(input logic [3:0] d);
        begin
            case (d)
                4'd0:    glyph = 8'h3F;
                4'd1:    glyph = 8'h06;
                4'd2:    glyph = 8'h5B;
                4'd3:    glyph = 8'h4F;
                4'd4:    glyph = 8'h66;
                4'd5:    glyph = 8'h6D;
                4'd6:    glyph = 8'h7D;
                4'd7:    glyph = 8'h07;
                4'd8:    glyph = 8'h7F;
                default: glyph = 8'h6F;
            endcase
        end
    endfunction

    logic [7:0] min_bcd;
    logic [7:0] sec_bcd;
    logic [3:0] digit_val;
    logic [7:0] code;
    logic       blank;

    assign min_bcd = split_bcd(minute_count);
    assign sec_bcd = split_bcd(second_count);

    // digit for this scan position
    always_comb begin
        case (ctrl.scan_pos)
            2'd0:    digit_val = min_bcd[7:4];
            2'd1:    digit_val = min_bcd[3:0];
            2'd2:    digit_val = sec_bcd[7:4];
            default: digit_val = sec_bcd[3:0];
        endcase
    end

    // field being set blanks during the off half of the blink
    assign blank = ((ctrl.mode == mmss_pkg::MODE_SET_MIN) && !ctrl.scan_pos[1]) ||
                   ((ctrl.mode == mmss_pkg::MODE_SET_SEC) &&  ctrl.scan_pos[1]);

    // glyph, decimal point on digit 1, polarity and blanking
    always_comb begin
        code = glyph(digit_val);
        if (ctrl.scan_pos == 2'd1) begin
            code[7] = 1'b1;
        end
        if (!ctrl.common_cathode) begin
            code = ~code;
        end
        if (blank && !ctrl.blink_visible) begin
            code = ctrl.common_cathode ? 8'h00 : 8'hFF;
        end
    end

    // pin remap: A7 B5 C1 D3 E4 F6 G0 DP2
    assign segment_pins = {code[0], code[5], code[1], code[4],
                           code[3], code[7], code[2], code[6]};

    // active-low enable, display index i on bit 3-i
    assign digit_select = ~(4'b1000 >> ctrl.scan_pos);

endmodule

// File: sv/mmss_clock_with_seven_segment_scan_core.sv
// ----------------------------------------------------------------------------
// mmss_clock_with_seven_segment_scan_core - MM:SS clock with scanned display
// Handles key edges (mode, add, sub, ok), refreshes one multiplexed digit per
// tick, and runs the blink and seconds counters with carry to hours.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_tick s_key_*_level    | in
//  result  | m_valid m_ready m_segment_pins ...      | out
//  config  | cfg_wr_en cfg_index cfg_wdata           | in
//
// One word per cycle while the result is not stalled: a word is taken in one cycle and its
// result shows in the next, set by the single register stage holding the clock state.
// The state registers drive the result ports; a stalled result holds them
// and the input waits until the result is taken.
// Reset (synchronous, active low) restores 12:12:00, normal mode, display off.
// ----------------------------------------------------------------------------
module mmss_clock_with_seven_segment_scan_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [mmss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mmss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_tick,
    input  logic                              s_key_mode_level,
    input  logic                              s_key_add_level,
    input  logic                              s_key_sub_level,
    input  logic                              s_key_ok_level,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_segment_pins,
    output logic [3:0]                        m_digit_select,
    output logic [5:0]                        m_minutes,
    output logic [5:0]                        m_seconds,
    output logic [4:0]                        m_hours,
    output logic [1:0]                        m_set_mode
);

    // configuration registers
    logic [15:0] ticks_per_second_reg;
    logic [15:0] blink_half_period_reg;
    logic        common_cathode_reg;

    // clock state
    logic [4:0]      hour_reg,        hour_next;
    logic [5:0]      minute_reg,      minute_next;
    logic [5:0]      second_reg,      second_next;
    logic [15:0]     tick_cnt_reg,    tick_cnt_next;
    logic [15:0]     blink_cnt_reg,   blink_cnt_next;
    logic            blink_vis_reg,   blink_vis_next;
    logic [1:0]      scan_pos_reg,    scan_pos_next;
    mmss_pkg::mode_t mode_reg,        mode_next;
    logic [3:0]      keys_reg;
    logic [7:0]      segment_reg,     segment_next;
    logic [3:0]      digit_reg,       digit_next;
    logic            m_valid_reg;

    logic [3:0]           keys_now;
    logic [3:0]           fell;
    logic                 accept;
    mmss_pkg::disp_ctrl_t disp_ctrl;
    logic [7:0]           enc_segment;
    logic [3:0]           enc_digit;
    logic [15:0]          blink_sum;
    logic [15:0]          tick_sum;

    // keys: bit 0 mode, 1 add, 2 sub, 3 ok
    assign keys_now = {s_key_ok_level, s_key_sub_level, s_key_add_level, s_key_mode_level};
    assign fell     = keys_reg & ~keys_now;
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // key handling, in the order mode, add, sub, ok
    always_comb begin
        mode_next      = mode_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        blink_cnt_next = blink_cnt_reg;
        blink_vis_next = blink_vis_reg;
        hour_next      = hour_reg;
        tick_cnt_next  = tick_cnt_reg;

        if (fell[0]) begin
            case (mode_reg)
                mmss_pkg::MODE_NORMAL:  mode_next = mmss_pkg::MODE_SET_MIN;
                mmss_pkg::MODE_SET_MIN: mode_next = mmss_pkg::MODE_SET_SEC;
                default:                mode_next = mmss_pkg::MODE_NORMAL;
            endcase
            blink_cnt_next = 16'd0;
            blink_vis_next = 1'b1;
        end
        if (fell[1]) begin
            if (mode_next == mmss_pkg::MODE_SET_MIN) begin
                minute_next = (minute_next >= mmss_pkg::SEC_LAST) ? 6'd0 : minute_next + 6'd1;
            end else if (mode_next == mmss_pkg::MODE_SET_SEC) begin
                second_next = (second_next >= mmss_pkg::SEC_LAST) ? 6'd0 : second_next + 6'd1;
            end
        end
        if (fell[2]) begin
            if (mode_next == mmss_pkg::MODE_SET_MIN) begin
                minute_next = (minute_next == 6'd0) ? mmss_pkg::SEC_LAST : minute_next - 6'd1;
            end else if (mode_next == mmss_pkg::MODE_SET_SEC) begin
                second_next = (second_next == 6'd0) ? mmss_pkg::SEC_LAST : second_next - 6'd1;
            end
        end
        if (fell[3]) begin
            second_next    = 6'd0;
            mode_next      = mmss_pkg::MODE_NORMAL;
            blink_cnt_next = 16'd0;
            blink_vis_next = 1'b1;
        end
    end

    // display content from the time after key handling
    assign disp_ctrl = '{mode:           mode_next,
                         blink_visible:  blink_vis_next,
                         common_cathode: common_cathode_reg,
                         scan_pos:       scan_pos_reg};

    mmss_seg_enc u_seg_enc (
        .minute_count (minute_next),
        .second_count (second_next),
        .ctrl         (disp_ctrl),
        .segment_pins (enc_segment),
        .digit_select (enc_digit)
    );

    assign blink_sum = blink_cnt_next + 16'd1;
    assign tick_sum  = tick_cnt_reg + 16'd1;

    // tick: refresh one digit, run blink and second counters
    logic [4:0]  hour_tick;
    logic [5:0]  minute_tick;
    logic [5:0]  second_tick;
    logic [15:0] blink_cnt_tick;
    logic        blink_vis_tick;
    logic [15:0] tick_cnt_tick;

    always_comb begin
        hour_tick      = hour_reg;
        minute_tick    = minute_next;
        second_tick    = second_next;
        blink_cnt_tick = blink_sum;
        blink_vis_tick = blink_vis_next;
        tick_cnt_tick  = tick_sum;
        if (blink_sum >= blink_half_period_reg) begin
            blink_cnt_tick = 16'd0;
            blink_vis_tick = !blink_vis_next;
        end
        if (tick_sum >= ticks_per_second_reg) begin
            tick_cnt_tick = 16'd0;
            if (second_next >= mmss_pkg::SEC_LAST) begin
                second_tick = 6'd0;
                if (minute_next >= mmss_pkg::SEC_LAST) begin
                    minute_tick = 6'd0;
                    hour_tick   = (hour_reg >= mmss_pkg::HOUR_LAST) ? 5'd0 : hour_reg + 5'd1;
                end else begin
                    minute_tick = minute_next + 6'd1;
                end
            end else begin
                second_tick = second_next + 6'd1;
            end
        end
    end

    // select tick or no-tick results
    logic [4:0]  hour_sel;
    logic [5:0]  minute_sel;
    logic [5:0]  second_sel;
    logic [15:0] blink_cnt_sel;
    logic        blink_vis_sel;

    always_comb begin
        if (s_tick) begin
            hour_sel      = hour_tick;
            minute_sel    = minute_tick;
            second_sel    = second_tick;
            blink_cnt_sel = blink_cnt_tick;
            blink_vis_sel = blink_vis_tick;
            segment_next  = enc_segment;
            digit_next    = enc_digit;
            scan_pos_next = scan_pos_reg + 2'd1;
        end else begin
            hour_sel      = hour_next;
            minute_sel    = minute_next;
            second_sel    = second_next;
            blink_cnt_sel = blink_cnt_next;
            blink_vis_sel = blink_vis_next;
            segment_next  = segment_reg;
            digit_next    = digit_reg;
            scan_pos_next = scan_pos_reg;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_second_reg  <= mmss_pkg::TICKS_PER_SECOND_RST;
            blink_half_period_reg <= mmss_pkg::BLINK_HALF_PERIOD_RST;
            common_cathode_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mmss_pkg::REG_TICKS_PER_SECOND:  ticks_per_second_reg  <= cfg_wdata;
                mmss_pkg::REG_BLINK_HALF_PERIOD: blink_half_period_reg <= cfg_wdata;
                mmss_pkg::REG_COMMON_CATHODE:    common_cathode_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clock state, updated once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg      <= mmss_pkg::HOUR_RST;
            minute_reg    <= mmss_pkg::MINUTE_RST;
            second_reg    <= 6'd0;
            tick_cnt_reg  <= 16'd0;
            blink_cnt_reg <= 16'd0;
            blink_vis_reg <= 1'b1;
            scan_pos_reg  <= 2'd0;
            mode_reg      <= mmss_pkg::MODE_NORMAL;
            keys_reg      <= 4'hF;
            segment_reg   <= 8'hFF;
            digit_reg     <= 4'hF;
        end else if (accept) begin
            hour_reg      <= hour_sel;
            minute_reg    <= minute_sel;
            second_reg    <= second_sel;
            tick_cnt_reg  <= s_tick ? tick_cnt_tick : tick_cnt_next;
            blink_cnt_reg <= blink_cnt_sel;
            blink_vis_reg <= blink_vis_sel;
            scan_pos_reg  <= scan_pos_next;
            mode_reg      <= mode_next;
            keys_reg      <= keys_now;
            segment_reg   <= segment_next;
            digit_reg     <= digit_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_segment_pins = segment_reg;
    assign m_digit_select = digit_reg;
    assign m_minutes      = minute_reg;
    assign m_seconds      = second_reg;
    assign m_hours        = hour_reg;
    assign m_set_mode     = mode_reg;

endmodule

// File: sv/mmss_checker.sv
// ----------------------------------------------------------------------------
// mmss_checker - port-level checks of the seven-segment scan clock
// Watches the result channel for time ranges, digit enables, mode codes,
// display hold on words without a tick and hold of a stalled result.
// ----------------------------------------------------------------------------
module mmss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_tick,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_segment_pins,
    input logic [3:0] m_digit_select,
    input logic [5:0] m_minutes,
    input logic [5:0] m_seconds,
    input logic [4:0] m_hours,
    input logic [1:0] m_set_mode
);

    // time fields stay in range
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_minutes < 6'd60) && (m_seconds < 6'd60) && (m_hours < 5'd24))
        else $error("time field out of range");

    // at most one digit enabled, and a valid mode code
    a_digit_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($countones(~m_digit_select) <= 1) &&
                    (m_set_mode != 2'd3))
        else $error("bad digit enable or mode code");

    // a word without a tick leaves the display unchanged
    a_no_tick_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_tick) |=>
            $stable(m_segment_pins) && $stable(m_digit_select))
        else $error("display changed without a tick");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_seconds) && $stable(m_minutes))
        else $error("stalled result changed");

endmodule

bind mmss_clock_with_seven_segment_scan_core mmss_checker u_mmss_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_tick         (s_tick),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_segment_pins (m_segment_pins),
    .m_digit_select (m_digit_select),
    .m_minutes      (m_minutes),
    .m_seconds      (m_seconds),
    .m_hours        (m_hours),
    .m_set_mode     (m_set_mode)
);
